// ===== rtl/mck_pkg.sv =====
// shared types, register codes and the morse pattern table of the character keyer
`timescale 1ns / 1ps
`default_nettype none

package mck_pkg;

  localparam int CHAR_W   = 8;
  localparam int CFG_W    = 16;
  localparam int DUR_W    = 17;
  localparam int REG_IDX_W = 3;
  localparam int NUM_REGS = 6;
  localparam int SYM_MAX  = 5;
  localparam int SYM_IDX_W = 3;

  localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;

  // configuration register codes, also the address in the register memory
  typedef enum logic [REG_IDX_W-1:0] {
    REG_DOT    = 3'd0,
    REG_DASH   = 3'd1,
    REG_RELAX  = 3'd2,
    REG_LETTER = 3'd3,
    REG_WORD   = 3'd4,
    REG_TONE   = 3'd5
  } reg_idx_t;

  // kind of keying segment
  typedef enum logic [1:0] {
    SEG_MARK,
    SEG_RELAX,
    SEG_WORD,
    SEG_CLOSE
  } seg_kind_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TONE,
    ST_EMIT
  } state_t;

  // symbol pattern: first symbol in bit 0, a set bit is a dash
  typedef struct packed {
    logic [SYM_IDX_W-1:0] len;
    logic [SYM_MAX-1:0]   bits;
  } pat_t;

  function automatic logic [CFG_W-1:0] reg_reset_val(input reg_idx_t idx);
    logic [CFG_W-1:0] v;
    case (idx)
      REG_DOT:    v = 16'd100;
      REG_DASH:   v = 16'd300;
      REG_RELAX:  v = 16'd100;
      REG_LETTER: v = 16'd300;
      REG_WORD:   v = 16'd700;
      REG_TONE:   v = 16'd1000;
      default:    v = '0;
    endcase
    return v;
  endfunction

  function automatic pat_t pat_lookup(input logic [CHAR_W-1:0] c);
    pat_t p;
    case (c)
      8'h41: p = '{3'd2, 5'b00010}; // A
      8'h42: p = '{3'd4, 5'b00001}; // B
      8'h43: p = '{3'd4, 5'b00101}; // C
      8'h44: p = '{3'd3, 5'b00001}; // D
      8'h45: p = '{3'd1, 5'b00000}; // E
      8'h46: p = '{3'd4, 5'b00100}; // F
      8'h47: p = '{3'd3, 5'b00011}; // G
      8'h48: p = '{3'd4, 5'b00000}; // H
      8'h49: p = '{3'd2, 5'b00000}; // I
      8'h4A: p = '{3'd4, 5'b01110}; // J
      8'h4B: p = '{3'd3, 5'b00101}; // K
      8'h4C: p = '{3'd4, 5'b00010}; // L
      8'h4D: p = '{3'd2, 5'b00011}; // M
      8'h4E: p = '{3'd2, 5'b00001}; // N
      8'h4F: p = '{3'd3, 5'b00111}; // O
      8'h50: p = '{3'd4, 5'b00110}; // P
      8'h51: p = '{3'd4, 5'b01011}; // Q
      8'h52: p = '{3'd3, 5'b00010}; // R
      8'h53: p = '{3'd3, 5'b00000}; // S
      8'h54: p = '{3'd1, 5'b00001}; // T
      8'h55: p = '{3'd3, 5'b00100}; // U
      8'h56: p = '{3'd4, 5'b01000}; // V
      8'h57: p = '{3'd3, 5'b00110}; // W
      8'h58: p = '{3'd4, 5'b01001}; // X
      8'h59: p = '{3'd4, 5'b01101}; // Y
      8'h5A: p = '{3'd4, 5'b00011}; // Z
      8'h30: p = '{3'd5, 5'b11111}; // 0
      8'h31: p = '{3'd5, 5'b11110}; // 1
      8'h32: p = '{3'd5, 5'b11100}; // 2
      8'h33: p = '{3'd5, 5'b11000}; // 3
      8'h34: p = '{3'd5, 5'b10000}; // 4
      8'h35: p = '{3'd5, 5'b00000}; // 5
      8'h36: p = '{3'd5, 5'b00001}; // 6
      8'h37: p = '{3'd5, 5'b00011}; // 7
      8'h38: p = '{3'd5, 5'b00111}; // 8
      8'h39: p = '{3'd5, 5'b01111}; // 9
      default: p = '{3'd0, 5'b00000};
    endcase
    return p;
  endfunction

  // register that holds the length of a given segment
  function automatic reg_idx_t seg_addr(input seg_kind_t kind,
                                        input logic [SYM_IDX_W-1:0] sym,
                                        input pat_t pat);
    reg_idx_t a;
    case (kind)
      SEG_MARK:  a = pat.bits[sym] ? REG_DASH : REG_DOT;
      SEG_RELAX: a = REG_RELAX;
      SEG_WORD:  a = REG_WORD;
      SEG_CLOSE: a = REG_LETTER;
      default:   a = REG_LETTER;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/mck_in_if.sv =====
// character input channel
`timescale 1ns / 1ps
`default_nettype none

interface mck_in_if;
  logic                      valid;
  logic                      ready;
  logic [mck_pkg::CHAR_W-1:0] char_code;

  modport source (output valid, output char_code, input ready);
  modport sink   (input valid, input char_code, output ready);
endinterface

`default_nettype wire

// ===== rtl/mck_out_if.sv =====
// keying segment output channel
`timescale 1ns / 1ps
`default_nettype none

interface mck_out_if;
  logic                      valid;
  logic                      ready;
  logic                      tone_on;
  logic [mck_pkg::CFG_W-1:0] pitch_hz;
  logic [mck_pkg::DUR_W-1:0] duration_ms;
  logic                      last_segment;

  modport source (output valid, output tone_on, output pitch_hz, output duration_ms,
                  output last_segment, input ready);
  modport sink   (input valid, input tone_on, input pitch_hz, input duration_ms,
                  input last_segment, output ready);
endinterface

`default_nettype wire

// ===== rtl/mck_cfg_if.sv =====
// configuration write channel
`timescale 1ns / 1ps
`default_nettype none

interface mck_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [mck_pkg::REG_IDX_W-1:0] index;
  logic [mck_pkg::CFG_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/morse_character_keyer_unit.sv =====
// morse character keyer: register memory, segment sequencer and output register
// the first segment of a character goes through ST_TONE and ST_EMIT into the output register
// throughput: one segment per cycle while the output is not stalled; a character is its
//   pitch fetch plus 1 to 11 segments; the single read port of the register
//   memory gives one length lookup per cycle
// reset: rst_n synchronous active low; registers read their reset values until written
`timescale 1ns / 1ps
`default_nettype none

module morse_character_keyer_unit (
  input  wire logic clk,
  input  wire logic rst_n,
  mck_in_if.sink    in_ch,
  mck_out_if.source out_ch,
  mck_cfg_if.sink   cfg_ch
);
  import mck_pkg::*;

  // register memory and its valid bits
  logic [CFG_W-1:0]    cfg_mem [0:NUM_REGS-1];
  logic [NUM_REGS-1:0] cfg_vld_r;
  logic                cfg_wr;

  // read port
  logic              rd_en;
  reg_idx_t          rd_addr;
  reg_idx_t          rd_addr_r;
  logic [CFG_W-1:0]  rd_data_r;
  logic              rd_vld_r;
  logic [CFG_W-1:0]  rd_val;

  // sequencer
  state_t               state_r, state_nxt;
  pat_t                 pat_r, pat_nxt;
  seg_kind_t            kind_r, kind_nxt;
  logic [SYM_IDX_W-1:0] sym_r, sym_nxt;
  logic [CFG_W-1:0]     tone_r, tone_nxt;
  pat_t                 in_pat;
  logic                 in_beat;
  logic                 out_free;
  logic                 out_load;

  // output register
  logic             out_vld_r;
  logic             out_tone_r;
  logic [CFG_W-1:0] out_pitch_r;
  logic [DUR_W-1:0] out_dur_r;
  logic             out_last_r;

  assign cfg_ch.ready = 1'b1;
  assign cfg_wr       = cfg_ch.valid && (cfg_ch.index <= REG_TONE);

  // register memory write
  always_ff @(posedge clk) begin
    if (cfg_wr) begin
      cfg_mem[cfg_ch.index] <= cfg_ch.data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_vld_r <= '0;
    end else if (cfg_wr) begin
      cfg_vld_r[cfg_ch.index] <= 1'b1;
    end
  end

  // register memory read, registered data, valid bit and address
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= cfg_mem[rd_addr];
      rd_vld_r  <= cfg_vld_r[rd_addr];
      rd_addr_r <= rd_addr;
    end
  end

  assign rd_val = rd_vld_r ? rd_data_r : reg_reset_val(rd_addr_r);

  assign in_beat  = in_ch.valid && in_ch.ready;
  assign in_pat   = pat_lookup(in_ch.char_code);
  assign out_free = !out_vld_r || out_ch.ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) state_nxt = ST_TONE;
      end
      ST_TONE: state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free && kind_r == SEG_CLOSE) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // sequencer outputs: input ready, reads, segment stepping, output load
  always_comb begin
    in_ch.ready = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = REG_DOT;
    out_load    = 1'b0;
    pat_nxt     = pat_r;
    kind_nxt    = kind_r;
    sym_nxt     = sym_r;
    tone_nxt    = tone_r;
    case (state_r)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          rd_en   = 1'b1;
          rd_addr = REG_TONE;
          pat_nxt = in_pat;
          sym_nxt = '0;
          if (in_pat.len != '0) begin
            kind_nxt = SEG_MARK;
          end else if (in_ch.char_code == CHAR_SPACE) begin
            kind_nxt = SEG_WORD;
          end else begin
            kind_nxt = SEG_CLOSE;
          end
        end
      end
      ST_TONE: begin
        tone_nxt = rd_val;
        rd_en    = 1'b1;
        rd_addr  = seg_addr(kind_r, sym_r, pat_r);
      end
      ST_EMIT: begin
        if (out_free) begin
          out_load = 1'b1;
          if (kind_r != SEG_CLOSE) begin
            case (kind_r)
              SEG_MARK: kind_nxt = SEG_RELAX;
              SEG_RELAX: begin
                if (sym_r + 3'd1 < pat_r.len) begin
                  kind_nxt = SEG_MARK;
                  sym_nxt  = sym_r + 3'd1;
                end else begin
                  kind_nxt = SEG_CLOSE;
                end
              end
              default: kind_nxt = SEG_CLOSE;
            endcase
            rd_en   = 1'b1;
            rd_addr = seg_addr(kind_nxt, sym_nxt, pat_r);
          end
        end
      end
      default: ;
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= SEG_CLOSE;
      sym_r   <= '0;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      sym_r   <= sym_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pat_r  <= pat_nxt;
    tone_r <= tone_nxt;
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_load) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_tone_r  <= (kind_r == SEG_MARK);
      out_pitch_r <= (kind_r == SEG_MARK) ? tone_r : '0;
      out_dur_r   <= (kind_r == SEG_CLOSE) ? {rd_val, 1'b0} : {1'b0, rd_val};
      out_last_r  <= (kind_r == SEG_CLOSE);
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.tone_on      = out_tone_r;
  assign out_ch.pitch_hz     = out_pitch_r;
  assign out_ch.duration_ms  = out_dur_r;
  assign out_ch.last_segment = out_last_r;

  // an accepted character always starts with the pitch fetch
  a_beat_to_tone: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> state_r == ST_TONE)
    else $error("input beat not followed by pitch fetch");

  // the closing segment ends the character
  a_close_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && out_load && kind_r == SEG_CLOSE) |=>
      (state_r == ST_IDLE && out_vld_r && out_last_r))
    else $error("closing segment did not end the character");

  // symbol index stays inside the pattern
  a_sym_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE && (kind_r == SEG_MARK || kind_r == SEG_RELAX)) |->
      sym_r < pat_r.len)
    else $error("symbol index beyond pattern length");

  // a stalled segment keeps the length it read
  a_stall_holds_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && !out_free) |=> $stable(rd_val))
    else $error("segment length changed while the output was stalled");

endmodule

`default_nettype wire
